/* src/msid_pkg.sv */
package msid_pkg;

  // mnemonic codes, 0 is undefined
  localparam logic [4:0] MN_UNDEF   = 5'd0;
  localparam logic [4:0] MN_SLL     = 5'd1;
  localparam logic [4:0] MN_SRL     = 5'd2;
  localparam logic [4:0] MN_SRA     = 5'd3;
  localparam logic [4:0] MN_JR      = 5'd4;
  localparam logic [4:0] MN_SYSCALL = 5'd5;
  localparam logic [4:0] MN_MFHI    = 5'd6;
  localparam logic [4:0] MN_MFLO    = 5'd7;
  localparam logic [4:0] MN_MULT    = 5'd8;
  localparam logic [4:0] MN_ADD     = 5'd9;
  localparam logic [4:0] MN_SUB     = 5'd10;
  localparam logic [4:0] MN_AND     = 5'd11;
  localparam logic [4:0] MN_OR      = 5'd12;
  localparam logic [4:0] MN_XOR     = 5'd13;
  localparam logic [4:0] MN_NOR     = 5'd14;
  localparam logic [4:0] MN_SLT     = 5'd15;
  localparam logic [4:0] MN_BLTZ    = 5'd16;
  localparam logic [4:0] MN_J       = 5'd17;
  localparam logic [4:0] MN_JAL     = 5'd18;
  localparam logic [4:0] MN_BEQ     = 5'd19;
  localparam logic [4:0] MN_BNE     = 5'd20;
  localparam logic [4:0] MN_ADDI    = 5'd21;
  localparam logic [4:0] MN_SLTI    = 5'd22;
  localparam logic [4:0] MN_ANDI    = 5'd23;
  localparam logic [4:0] MN_ORI     = 5'd24;
  localparam logic [4:0] MN_XORI    = 5'd25;
  localparam logic [4:0] MN_LUI     = 5'd26;
  localparam logic [4:0] MN_LB      = 5'd27;
  localparam logic [4:0] MN_LW      = 5'd28;
  localparam logic [4:0] MN_LBU     = 5'd29;
  localparam logic [4:0] MN_SB      = 5'd30;
  localparam logic [4:0] MN_SW      = 5'd31;

  // operand format classes
  localparam logic [3:0] FMT_NONE    = 4'd0;
  localparam logic [3:0] FMT_SHIFT   = 4'd1;
  localparam logic [3:0] FMT_JR      = 4'd2;
  localparam logic [3:0] FMT_SYSCALL = 4'd3;
  localparam logic [3:0] FMT_MFHILO  = 4'd4;
  localparam logic [3:0] FMT_MULT    = 4'd5;
  localparam logic [3:0] FMT_ALU     = 4'd6;
  localparam logic [3:0] FMT_ALUI    = 4'd7;
  localparam logic [3:0] FMT_BRANCH  = 4'd8;
  localparam logic [3:0] FMT_JUMP    = 4'd9;

  // opcode and funct halves
  localparam logic [2:0] HALF_MASK = 3'h7;

  localparam logic [5:0] OP_SPECIAL = 6'o00;
  localparam logic [5:0] OP_REGIMM  = 6'o01;
  localparam logic [5:0] OP_J       = 6'o02;
  localparam logic [5:0] OP_JAL     = 6'o03;
  localparam logic [5:0] OP_BEQ     = 6'o04;
  localparam logic [5:0] OP_BNE     = 6'o05;
  localparam logic [5:0] OP_ADDI    = 6'o10;
  localparam logic [5:0] OP_SLTI    = 6'o12;
  localparam logic [5:0] OP_ANDI    = 6'o14;
  localparam logic [5:0] OP_ORI     = 6'o15;
  localparam logic [5:0] OP_XORI    = 6'o16;
  localparam logic [5:0] OP_LUI     = 6'o17;
  localparam logic [5:0] OP_LB      = 6'o40;
  localparam logic [5:0] OP_LW      = 6'o43;
  localparam logic [5:0] OP_LBU     = 6'o44;
  localparam logic [5:0] OP_SB      = 6'o50;
  localparam logic [5:0] OP_SW      = 6'o53;

  localparam logic [5:0] FN_SLL     = 6'o00;
  localparam logic [5:0] FN_SRL     = 6'o02;
  localparam logic [5:0] FN_SRA     = 6'o03;
  localparam logic [5:0] FN_JR      = 6'o10;
  localparam logic [5:0] FN_SYSCALL = 6'o14;
  localparam logic [5:0] FN_MFHI    = 6'o20;
  localparam logic [5:0] FN_MFLO    = 6'o22;
  localparam logic [5:0] FN_MULT    = 6'o30;
  localparam logic [5:0] FN_ADD     = 6'o40;
  localparam logic [5:0] FN_SUB     = 6'o42;
  localparam logic [5:0] FN_AND     = 6'o44;
  localparam logic [5:0] FN_OR      = 6'o45;
  localparam logic [5:0] FN_XOR     = 6'o46;
  localparam logic [5:0] FN_NOR     = 6'o47;
  localparam logic [5:0] FN_SLT     = 6'o52;

  localparam logic [2:0] FH_SHIFT  = 3'd0;
  localparam logic [2:0] FH_JR     = 3'd1;
  localparam logic [2:0] FH_MFHILO = 3'd2;
  localparam logic [2:0] FH_MULT   = 3'd3;
  localparam logic [2:0] FH_ALU0   = 3'd4;
  localparam logic [2:0] FH_ALU1   = 3'd5;

  typedef struct packed {
    logic [4:0] mnemonic;
    logic [3:0] operand_format;
    logic       is_load_store;
  } dec_t;

  // recognize an R-type funct
  function automatic logic [4:0] rtype_mn(input logic [5:0] funct);
    logic [4:0] mn;
    mn = MN_UNDEF;
    case (funct)
      FN_SLL:     mn = MN_SLL;
      FN_SRL:     mn = MN_SRL;
      FN_SRA:     mn = MN_SRA;
      FN_JR:      mn = MN_JR;
      FN_SYSCALL: mn = MN_SYSCALL;
      FN_MFHI:    mn = MN_MFHI;
      FN_MFLO:    mn = MN_MFLO;
      FN_MULT:    mn = MN_MULT;
      FN_ADD:     mn = MN_ADD;
      FN_SUB:     mn = MN_SUB;
      FN_AND:     mn = MN_AND;
      FN_OR:      mn = MN_OR;
      FN_XOR:     mn = MN_XOR;
      FN_NOR:     mn = MN_NOR;
      FN_SLT:     mn = MN_SLT;
      default:    mn = MN_UNDEF;
    endcase
    return mn;
  endfunction

  // format from the high half of funct
  function automatic logic [3:0] rtype_fmt(input logic [2:0] fhi);
    logic [3:0] fmt;
    fmt = FMT_NONE;
    case (fhi)
      FH_SHIFT:  fmt = FMT_SHIFT;
      FH_JR:     fmt = FMT_JR;
      FH_MFHILO: fmt = FMT_MFHILO;
      FH_MULT:   fmt = FMT_MULT;
      FH_ALU0:   fmt = FMT_ALU;
      FH_ALU1:   fmt = FMT_ALU;
      default:   fmt = FMT_NONE;
    endcase
    return fmt;
  endfunction

  function automatic dec_t decode_word(input logic [31:0] word);
    logic [5:0] opcode;
    logic [5:0] funct;
    logic [4:0] rt;
    logic [4:0] mn;
    dec_t       d;
    opcode = word[31:26];
    funct  = word[5:0];
    rt     = word[20:16];
    mn     = rtype_mn(funct);
    d      = '{mnemonic: MN_UNDEF, operand_format: FMT_NONE, is_load_store: 1'b0};
    case (opcode)
      OP_SPECIAL: begin
        d.mnemonic = mn;
        if (mn == MN_SYSCALL) begin
          d.operand_format = FMT_SYSCALL;
        end else if (mn != MN_UNDEF) begin
          d.operand_format = rtype_fmt(funct[5:3] & HALF_MASK);
        end
      end
      OP_REGIMM: begin
        // only the rt == 0 encoding (bltz) is in the subset
        if (rt == 5'd0) begin
          d.mnemonic       = MN_BLTZ;
          d.operand_format = FMT_BRANCH;
        end
      end
      OP_J:    d = '{mnemonic: MN_J,    operand_format: FMT_JUMP,   is_load_store: 1'b0};
      OP_JAL:  d = '{mnemonic: MN_JAL,  operand_format: FMT_JUMP,   is_load_store: 1'b0};
      OP_BEQ:  d = '{mnemonic: MN_BEQ,  operand_format: FMT_BRANCH, is_load_store: 1'b0};
      OP_BNE:  d = '{mnemonic: MN_BNE,  operand_format: FMT_BRANCH, is_load_store: 1'b0};
      OP_ADDI: d = '{mnemonic: MN_ADDI, operand_format: FMT_ALUI,   is_load_store: 1'b0};
      OP_SLTI: d = '{mnemonic: MN_SLTI, operand_format: FMT_ALUI,   is_load_store: 1'b0};
      OP_ANDI: d = '{mnemonic: MN_ANDI, operand_format: FMT_ALUI,   is_load_store: 1'b0};
      OP_ORI:  d = '{mnemonic: MN_ORI,  operand_format: FMT_ALUI,   is_load_store: 1'b0};
      OP_XORI: d = '{mnemonic: MN_XORI, operand_format: FMT_ALUI,   is_load_store: 1'b0};
      OP_LUI:  d = '{mnemonic: MN_LUI,  operand_format: FMT_ALUI,   is_load_store: 1'b0};
      // loads and stores carry no format class, only the flag
      OP_LB:   d = '{mnemonic: MN_LB,   operand_format: FMT_NONE,   is_load_store: 1'b1};
      OP_LW:   d = '{mnemonic: MN_LW,   operand_format: FMT_NONE,   is_load_store: 1'b1};
      OP_LBU:  d = '{mnemonic: MN_LBU,  operand_format: FMT_NONE,   is_load_store: 1'b1};
      OP_SB:   d = '{mnemonic: MN_SB,   operand_format: FMT_NONE,   is_load_store: 1'b1};
      OP_SW:   d = '{mnemonic: MN_SW,   operand_format: FMT_NONE,   is_load_store: 1'b1};
      default: d = '{mnemonic: MN_UNDEF, operand_format: FMT_NONE,  is_load_store: 1'b0};
    endcase
    return d;
  endfunction

endpackage

/* src/mips_subset_instruction_decoder_core.sv */
// MIPS subset instruction decoder: each item is one 32-bit instruction word and yields
// one decoded item with a mnemonic code (0 = undefined), an operand format class, a
// load/store flag and the raw rs, rt, rd, shamt, sign-extended 16-bit immediate and
// 26-bit jump fields. The accepting edge captures the word in the input register;
// from there the decoded result is loaded into the result register, which raises
// out_valid. A new word can be taken every cycle, and throughput is one item per
// cycle, as long as out_stall is low.
// While out_stall is high the two registers fill and in_stall rises once both hold
// an item. The block keeps no state between items and has no configuration.
module mips_subset_instruction_decoder_core
  import msid_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // instruction channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [31:0]        in_instruction_word,
  // decoded channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [4:0]         out_mnemonic,
  output logic [3:0]         out_operand_format,
  output logic               out_is_load_store,
  output logic [4:0]         out_reg_s,
  output logic [4:0]         out_reg_t,
  output logic [4:0]         out_reg_d,
  output logic [4:0]         out_shift_amount,
  output logic signed [15:0] out_offset_value,
  output logic [25:0]        out_jump_index
);

  // stage 1: captured instruction word
  logic        s1_valid_r;
  logic [31:0] word_r;

  // stage 2: decoded result
  logic        s2_valid_r;
  dec_t        dec_r;
  logic [25:0] raw_r;

  dec_t        dec_nxt;
  logic        s2_load;
  logic        s1_load;

  // result register frees up when empty or when its item leaves this cycle
  assign s2_load  = !s2_valid_r || !out_stall;
  // input register moves on whenever the result register can take its item
  assign s1_load  = !s1_valid_r || s2_load;
  assign in_stall = !s1_load;

  // the whole decode is one short table lookup on opcode and funct
  assign dec_nxt = decode_word(word_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid_r <= in_valid;
      end
      if (s2_load) begin
        s2_valid_r <= s1_valid_r;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (s1_load && in_valid) begin
      word_r <= in_instruction_word;
    end
    if (s2_load && s1_valid_r) begin
      dec_r <= dec_nxt;
      raw_r <= word_r[25:0];
    end
  end

  assign out_valid          = s2_valid_r;
  assign out_mnemonic       = dec_r.mnemonic;
  assign out_operand_format = dec_r.operand_format;
  assign out_is_load_store  = dec_r.is_load_store;
  // raw fields pass through whatever the instruction is
  assign out_reg_s          = raw_r[25:21];
  assign out_reg_t          = raw_r[20:16];
  assign out_reg_d          = raw_r[15:11];
  assign out_shift_amount   = raw_r[10:6];
  assign out_offset_value   = $signed(raw_r[15:0]);
  assign out_jump_index     = raw_r[25:0];

endmodule

/* tb/msid_checker.sv */
module msid_checker
  import msid_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [31:0]        in_instruction_word,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [4:0]         out_mnemonic,
  input  logic [3:0]         out_operand_format,
  input  logic               out_is_load_store,
  input  logic [4:0]         out_reg_s,
  input  logic [4:0]         out_reg_t,
  input  logic [4:0]         out_reg_d,
  input  logic [4:0]         out_shift_amount,
  input  logic signed [15:0] out_offset_value,
  input  logic [25:0]        out_jump_index,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [4:0]         mnemonic;
    logic [3:0]         operand_format;
    logic               is_load_store;
    logic [4:0]         reg_s;
    logic [4:0]         reg_t;
    logic [4:0]         reg_d;
    logic [4:0]         shift_amount;
    logic signed [15:0] offset_value;
    logic [25:0]        jump_index;
  } decoded_item_t;

  decoded_item_t decoded_q[$];
  int            errors = 0;

  function automatic decoded_item_t predict_decode(input logic [31:0] word);
    decoded_item_t d;
    logic [4:0]    mn;
    logic [3:0]    fmt;
    logic          ls;
    mn  = MN_UNDEF;
    fmt = FMT_NONE;
    ls  = 1'b0;
    if (word[31:26] == OP_SPECIAL) begin
      case (word[5:0])
        FN_SLL:     begin mn = MN_SLL;     fmt = FMT_SHIFT;   end
        FN_SRL:     begin mn = MN_SRL;     fmt = FMT_SHIFT;   end
        FN_SRA:     begin mn = MN_SRA;     fmt = FMT_SHIFT;   end
        FN_JR:      begin mn = MN_JR;      fmt = FMT_JR;      end
        FN_SYSCALL: begin mn = MN_SYSCALL; fmt = FMT_SYSCALL; end
        FN_MFHI:    begin mn = MN_MFHI;    fmt = FMT_MFHILO;  end
        FN_MFLO:    begin mn = MN_MFLO;    fmt = FMT_MFHILO;  end
        FN_MULT:    begin mn = MN_MULT;    fmt = FMT_MULT;    end
        FN_ADD:     begin mn = MN_ADD;     fmt = FMT_ALU;     end
        FN_SUB:     begin mn = MN_SUB;     fmt = FMT_ALU;     end
        FN_AND:     begin mn = MN_AND;     fmt = FMT_ALU;     end
        FN_OR:      begin mn = MN_OR;      fmt = FMT_ALU;     end
        FN_XOR:     begin mn = MN_XOR;     fmt = FMT_ALU;     end
        FN_NOR:     begin mn = MN_NOR;     fmt = FMT_ALU;     end
        FN_SLT:     begin mn = MN_SLT;     fmt = FMT_ALU;     end
        default:    ;
      endcase
    end else begin
      case (word[31:26])
        OP_REGIMM: begin
          // bltz only when rt is zero
          if (word[20:16] == 5'd0) begin
            mn  = MN_BLTZ;
            fmt = FMT_BRANCH;
          end
        end
        OP_J:    begin mn = MN_J;    fmt = FMT_JUMP;   end
        OP_JAL:  begin mn = MN_JAL;  fmt = FMT_JUMP;   end
        OP_BEQ:  begin mn = MN_BEQ;  fmt = FMT_BRANCH; end
        OP_BNE:  begin mn = MN_BNE;  fmt = FMT_BRANCH; end
        OP_ADDI: begin mn = MN_ADDI; fmt = FMT_ALUI;   end
        OP_SLTI: begin mn = MN_SLTI; fmt = FMT_ALUI;   end
        OP_ANDI: begin mn = MN_ANDI; fmt = FMT_ALUI;   end
        OP_ORI:  begin mn = MN_ORI;  fmt = FMT_ALUI;   end
        OP_XORI: begin mn = MN_XORI; fmt = FMT_ALUI;   end
        OP_LUI:  begin mn = MN_LUI;  fmt = FMT_ALUI;   end
        OP_LB:   begin mn = MN_LB;   ls = 1'b1;        end
        OP_LW:   begin mn = MN_LW;   ls = 1'b1;        end
        OP_LBU:  begin mn = MN_LBU;  ls = 1'b1;        end
        OP_SB:   begin mn = MN_SB;   ls = 1'b1;        end
        OP_SW:   begin mn = MN_SW;   ls = 1'b1;        end
        default: ;
      endcase
    end
    d.mnemonic       = mn;
    d.operand_format = fmt;
    d.is_load_store  = ls;
    d.reg_s          = word[25:21];
    d.reg_t          = word[20:16];
    d.reg_d          = word[15:11];
    d.shift_amount   = word[10:6];
    d.offset_value   = word[15:0];
    d.jump_index     = word[25:0];
    return d;
  endfunction

  task automatic check_field(input string name, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, act_val);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    decoded_item_t exp_item;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        decoded_q.push_back(predict_decode(in_instruction_word));
      end
      if (out_valid && !out_stall) begin
        if (decoded_q.size() == 0) begin
          $error("decoded item with nothing outstanding");
          errors++;
        end else begin
          exp_item = decoded_q.pop_front();
          check_field("mnemonic", int'(exp_item.mnemonic), int'(out_mnemonic));
          check_field("operand_format", int'(exp_item.operand_format),
                      int'(out_operand_format));
          check_field("is_load_store", int'(exp_item.is_load_store),
                      int'(out_is_load_store));
          check_field("reg_s", int'(exp_item.reg_s), int'(out_reg_s));
          check_field("reg_t", int'(exp_item.reg_t), int'(out_reg_t));
          check_field("reg_d", int'(exp_item.reg_d), int'(out_reg_d));
          check_field("shift_amount", int'(exp_item.shift_amount),
                      int'(out_shift_amount));
          check_field("offset_value", int'(exp_item.offset_value),
                      int'(out_offset_value));
          check_field("jump_index", int'(exp_item.jump_index), int'(out_jump_index));
        end
      end
    end
    fail_count <= errors;
    pending    <= decoded_q.size();
  end

endmodule

/* tb/mips_subset_instruction_decoder_core_tb.sv */
module mips_subset_instruction_decoder_core_tb;
  import msid_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // generous bound on the whole run, far above the slowest legal run
  localparam int CYCLE_LIMIT    = 200000;
  // cycles the receiver holds off during the pressure stretch
  localparam int HOLD_CYCLES    = 120;
  // random items per phase
  localparam int ITEMS_PER_PASS = 370;
  // two register stages inside the block, plus margin
  localparam int DRAIN_CYCLES   = 8;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [31:0]        in_instruction_word;
  logic               out_valid;
  logic               out_stall;
  logic [4:0]         out_mnemonic;
  logic [3:0]         out_operand_format;
  logic               out_is_load_store;
  logic [4:0]         out_reg_s;
  logic [4:0]         out_reg_t;
  logic [4:0]         out_reg_d;
  logic [4:0]         out_shift_amount;
  logic signed [15:0] out_offset_value;
  logic [25:0]        out_jump_index;

  int fail_count;
  int pending;
  int cycle_count;

  // idling percentages; the sender's is used only by the stimulus process
  int send_idle_pct;
  int recv_stall_pct;
  // pressure requests from the stimulus, served by the receiver process
  int hold_req;

  mips_subset_instruction_decoder_core dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_instruction_word (in_instruction_word),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_mnemonic        (out_mnemonic),
    .out_operand_format  (out_operand_format),
    .out_is_load_store   (out_is_load_store),
    .out_reg_s           (out_reg_s),
    .out_reg_t           (out_reg_t),
    .out_reg_d           (out_reg_d),
    .out_shift_amount    (out_shift_amount),
    .out_offset_value    (out_offset_value),
    .out_jump_index      (out_jump_index)
  );

  msid_checker chk (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_instruction_word (in_instruction_word),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_mnemonic        (out_mnemonic),
    .out_operand_format  (out_operand_format),
    .out_is_load_store   (out_is_load_store),
    .out_reg_s           (out_reg_s),
    .out_reg_t           (out_reg_t),
    .out_reg_d           (out_reg_d),
    .out_shift_amount    (out_shift_amount),
    .out_offset_value    (out_offset_value),
    .out_jump_index      (out_jump_index),
    .fail_count          (fail_count),
    .pending             (pending)
  );

  // free-running clock, 10 ns period
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // run watchdog
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver: random stalls, or a long hold-off when one is requested
  always @(posedge clk) begin
    static int holds_served = 0;
    static int hold_left    = 0;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (hold_req != holds_served) begin
        holds_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // one recognized funct, chosen by index
  function automatic logic [5:0] pick_funct(input int idx);
    case (idx)
      0:       return FN_SLL;
      1:       return FN_SRL;
      2:       return FN_SRA;
      3:       return FN_JR;
      4:       return FN_SYSCALL;
      5:       return FN_MFHI;
      6:       return FN_MFLO;
      7:       return FN_MULT;
      8:       return FN_ADD;
      9:       return FN_SUB;
      10:      return FN_AND;
      11:      return FN_OR;
      12:      return FN_XOR;
      13:      return FN_NOR;
      default: return FN_SLT;
    endcase
  endfunction

  // one recognized non-special opcode, chosen by index
  function automatic logic [5:0] pick_opcode(input int idx);
    case (idx)
      0:       return OP_REGIMM;
      1:       return OP_J;
      2:       return OP_JAL;
      3:       return OP_BEQ;
      4:       return OP_BNE;
      5:       return OP_ADDI;
      6:       return OP_SLTI;
      7:       return OP_ANDI;
      8:       return OP_ORI;
      9:       return OP_XORI;
      10:      return OP_LUI;
      11:      return OP_LB;
      12:      return OP_LW;
      13:      return OP_LBU;
      14:      return OP_SB;
      default: return OP_SW;
    endcase
  endfunction

  // mostly well-formed words with random fields, some pure noise
  function automatic logic [31:0] random_word();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(9))
      0, 1: ;  // raw noise, mostly undefined opcodes
      2, 3, 4: begin
        w[31:26] = OP_SPECIAL;
        // mostly a legal funct, now and then an undefined one
        if ($urandom_range(4) != 0) w[5:0] = pick_funct($urandom_range(14));
      end
      5: begin
        // regimm, half of them with rt cleared so bltz shows up often
        w[31:26] = OP_REGIMM;
        if ($urandom_range(1) == 0) w[20:16] = 5'd0;
      end
      default: w[31:26] = pick_opcode($urandom_range(15));
    endcase
    return w;
  endfunction

  // offer one word and hold it until the block takes it
  task automatic send_word(input logic [31:0] w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid            <= 1'b1;
    in_instruction_word <= w;
    do @(posedge clk); while (in_stall);
  endtask

  initial begin
    rst_n               = 1'b0;
    in_valid            = 1'b0;
    in_instruction_word = 32'd0;
    send_idle_pct       = 0;
    recv_stall_pct      = 0;
    hold_req            = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed words, under the first idling mix
    send_idle_pct = 9;
    recv_stall_pct <= 81;
    send_word(32'h0000_0000);                                  // sll, all fields zero
    send_word(32'hFFFF_FFFF);                                  // undefined, all ones
    send_word({OP_SPECIAL, 20'hFFFFF, FN_SRA});                // sra, top register fields
    send_word({OP_SPECIAL, 20'h00000, 6'o01});                 // hole in the funct space
    send_word({OP_SPECIAL, 20'hAAAAA, FN_SYSCALL});            // syscall gets its own class
    send_word({OP_SPECIAL, 20'h55555, FN_JR});
    send_word({OP_SPECIAL, 20'hFFFFF, FN_MFHI});
    send_word({OP_SPECIAL, 20'h12345, FN_MULT});
    send_word({OP_SPECIAL, 20'hFFFFF, FN_SLT});
    send_word({OP_SPECIAL, 20'h00000, FN_NOR});
    send_word({OP_SPECIAL, 20'hFFFFF, 6'o77});                 // top funct, undefined
    send_word({OP_REGIMM, 5'd31, 5'd0, 16'hFFFF});             // bltz, rt zero
    send_word({OP_REGIMM, 5'd0, 5'd1, 16'h0000});              // bgez, outside the subset
    send_word({OP_REGIMM, 5'd31, 5'd31, 16'h8000});
    send_word({OP_J, 26'h3FF_FFFF});                           // largest jump index
    send_word({OP_JAL, 26'h000_0000});
    send_word({OP_ADDI, 5'd1, 5'd2, 16'h7FFF});                // most positive immediate
    send_word({OP_ADDI, 5'd31, 5'd0, 16'h8000});               // most negative immediate
    send_word({OP_LUI, 5'd0, 5'd31, 16'hFFFF});
    send_word({OP_LW, 5'd29, 5'd8, 16'hFFFF});                 // load, offset -1
    send_word({OP_SB, 5'd31, 5'd31, 16'h0000});                // store
    send_word({OP_LBU, 26'h2AA_AAAA});
    send_word({6'o77, 26'h000_0000});                          // top opcode, undefined
    send_word({6'o06, 26'h3FF_FFFF});                          // hole next to bne

    // random words: receiver mostly stalled
    repeat (ITEMS_PER_PASS) send_word(random_word());

    // sender mostly idle
    send_idle_pct = 81;
    recv_stall_pct <= 9;
    repeat (ITEMS_PER_PASS) send_word(random_word());

    // no idling; a long hold-off fills the block while words keep coming
    send_idle_pct = 0;
    recv_stall_pct <= 0;
    hold_req <= hold_req + 1;
    repeat (ITEMS_PER_PASS) send_word(random_word());
    in_valid <= 1'b0;

    // let everything outstanding come out
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
